FILE: hdl/json_string_escaper_defines.svh
// assertion macros shared by the json string escaper modules
// no dependencies; taken in by `include where assertions are written
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define JSE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("json string escaper: assertion failed");

// next-cycle implication, checked outside reset
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("json string escaper: assertion failed");

`endif

FILE: hdl/jse_pkg.sv
// types, character codes and classification helpers for the json string escaper
// no dependencies; imported by every module of the block
`default_nettype none

package jse_pkg;

   // input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   // output beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } rsp_type;

   // escape class of one input byte
   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_SHORT,
      KIND_UNICODE
   } kind_type;

   // classified byte handed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       eos;
   } desc_type;

   // queue sizing
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // beat index within one escape run
   localparam int BeatW = 3;
   localparam logic [BeatW-1:0] BeatFirst   = 3'd0;
   localparam logic [BeatW-1:0] BeatU       = 3'd1;
   localparam logic [BeatW-1:0] BeatZeroA   = 3'd2;
   localparam logic [BeatW-1:0] BeatZeroB   = 3'd3;
   localparam logic [BeatW-1:0] BeatHexHi   = 3'd4;
   localparam logic [BeatW-1:0] LastPass    = 3'd0;
   localparam logic [BeatW-1:0] LastShort   = 3'd1;
   localparam logic [BeatW-1:0] LastUnicode = 3'd5;

   // character codes
   localparam logic [7:0] CharQuote  = 8'h22;
   localparam logic [7:0] CharBslash = 8'h5C;
   localparam logic [7:0] CharBs     = 8'h08;
   localparam logic [7:0] CharFf     = 8'h0C;
   localparam logic [7:0] CharLf     = 8'h0A;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharCtlTop = 8'h20;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharLowA   = 8'h61;
   localparam logic [7:0] CharLowB   = 8'h62;
   localparam logic [7:0] CharLowF   = 8'h66;
   localparam logic [7:0] CharLowN   = 8'h6E;
   localparam logic [7:0] CharLowR   = 8'h72;
   localparam logic [7:0] CharLowT   = 8'h74;
   localparam logic [7:0] CharLowU   = 8'h75;

   // lower-case hex digit of one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         return CharZero + wide;
      end
      return CharLowA + wide - 8'd10;
   endfunction

   // sort a byte into its escape class
   function automatic desc_type classify(input req_type r);
      desc_type d;
      d.eos  = r.end_of_string;
      d.kind = KIND_SHORT;
      d.data = r.in_byte;
      unique case (r.in_byte)
         CharQuote:  d.data = CharQuote;
         CharBslash: d.data = CharBslash;
         CharBs:     d.data = CharLowB;
         CharFf:     d.data = CharLowF;
         CharLf:     d.data = CharLowN;
         CharCr:     d.data = CharLowR;
         CharTab:    d.data = CharLowT;
         default: begin
            if (r.in_byte < CharCtlTop) begin
               d.kind = KIND_UNICODE;
            end else begin
               d.kind = KIND_PASS;
            end
         end
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/jse_front.sv
// front end: accepts input beats and classifies each byte into an escape class
// depends on jse_pkg
`default_nettype none

module jse_front
   import jse_pkg::*;
(
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_data,
   input  wire logic     q_full,
   output logic          q_push,
   output desc_type      q_desc
);

   // accept whenever the queue has room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // classify the incoming byte
   assign q_desc = classify(req_data);

endmodule

`default_nettype wire

FILE: hdl/jse_queue.sv
// short queue of classified bytes between front and back
// depends on jse_pkg and json_string_escaper_defines.svh
`default_nettype none
`include "json_string_escaper_defines.svh"

module jse_queue
   import jse_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_desc,
   output logic          full,
   input  wire logic     pop,
   output logic          head_valid,
   output desc_type      head_desc
);

   desc_type            entry_ff [QDepth];
   logic [QPtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]    cnt_ff, cnt_in;

   assign full       = (cnt_ff == QCntW'(QDepth));
   assign head_valid = (cnt_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // checks
   `JSE_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= QCntW'(QDepth))
   `JSE_ASSERT_IMP(a_pop_nonempty, clock, reset, pop, cnt_ff != '0)
   `JSE_ASSERT_NEXT(a_cnt_grow, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule

`default_nettype wire

FILE: hdl/jse_back.sv
// back end: expands each classified byte into its escape run, one beat a cycle while the output is not stalled
// depends on jse_pkg and json_string_escaper_defines.svh
`default_nettype none
`include "json_string_escaper_defines.svh"

module jse_back
   import jse_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     head_valid,
   input  wire desc_type head_desc,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   logic [BeatW-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             load;
   logic             fire;
   logic             is_last;
   logic [BeatW-1:0] last_idx;
   logic [7:0]       beat_byte;

   // output register can take a new beat
   assign load = !rsp_valid_ff || !rsp_stall;
   assign fire = load && head_valid;

   // index of the final beat of this run
   always_comb begin
      unique case (head_desc.kind)
         KIND_PASS:    last_idx = LastPass;
         KIND_SHORT:   last_idx = LastShort;
         KIND_UNICODE: last_idx = LastUnicode;
         default:      last_idx = LastPass;
      endcase
   end

   assign is_last = (idx_ff == last_idx);
   assign pop     = fire && is_last;

   // byte of the current beat
   always_comb begin
      unique case (head_desc.kind)
         KIND_PASS: beat_byte = head_desc.data;
         KIND_SHORT: begin
            beat_byte = (idx_ff == BeatFirst) ? CharBslash : head_desc.data;
         end
         KIND_UNICODE: begin
            unique case (idx_ff)
               BeatFirst: beat_byte = CharBslash;
               BeatU:     beat_byte = CharLowU;
               BeatZeroA: beat_byte = CharZero;
               BeatZeroB: beat_byte = CharZero;
               BeatHexHi: beat_byte = hex_digit(head_desc.data[7:4]);
               default:   beat_byte = hex_digit(head_desc.data[3:0]);
            endcase
         end
         default: beat_byte = head_desc.data;
      endcase
   end

   // beat counter and output register next values
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = head_valid;
      end
      if (fire) begin
         idx_in                  = is_last ? BeatFirst : idx_ff + 1'b1;
         rsp_data_in.out_byte    = beat_byte;
         rsp_data_in.run_last    = is_last;
         rsp_data_in.string_done = is_last && head_desc.eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= BeatFirst;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `JSE_ASSERT_IMP(a_idx_bound, clock, reset, 1'b1, idx_ff <= LastUnicode)
   `JSE_ASSERT_IMP(a_mid_run_head, clock, reset, idx_ff != BeatFirst, head_valid)
   `JSE_ASSERT_IMP(a_open_run, clock, reset, rsp_valid_ff && !rsp_data_ff.run_last, idx_ff != BeatFirst)
   `JSE_ASSERT_IMP(a_done_on_last, clock, reset, rsp_valid_ff && rsp_data_ff.string_done, rsp_data_ff.run_last)

endmodule

`default_nettype wire

FILE: hdl/json_string_escaper.sv
// JSON string escaper: takes one string byte per input beat and emits its escaped form as
// a run of one, two or six output beats. A byte that passes through unchanged is a run of
// one beat, so plain text streams at one byte per clock while the output is not stalled. A
// quote, backslash or named control character becomes a two-beat run and any other control
// byte a six-beat run; the output side sets the pace then, and a four-entry queue behind
// the classifier keeps taking input beats until it fills. An accepted input beat is written
// into the queue and reaches the output register from the queue head. run_last marks
// the last beat of each run and string_done marks that beat when the input carried
// end_of_string. Only the queue and the output register hold state across runs.
// depends on jse_pkg, jse_front, jse_queue and jse_back
`default_nettype none

module json_string_escaper
   import jse_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic     q_full;
   logic     q_push;
   desc_type q_desc;
   logic     q_pop;
   logic     q_head_valid;
   desc_type q_head_desc;

   // classify incoming bytes
   jse_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_desc    (q_desc)
   );

   // decouple front and back
   jse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_desc),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_desc  (q_head_desc)
   );

   // expand escape runs
   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_desc  (q_head_desc),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
